FILE: hdl/bssc_pkg.sv
// ----------------------------------------------------------------------------
// bssc_pkg
// Shared constants, types and tables for the six-step commutation block.
// ----------------------------------------------------------------------------
package bssc_pkg;

  localparam int ANGLE_BITS       = 14;
  localparam int SECTORS_PER_TURN = 42;

  localparam int ANGLE_W = 14;
  localparam int DUTY_W  = 16;
  localparam int MAG_W   = 15;
  localparam int SEC_W   = 3;

  localparam int AW     = ANGLE_BITS;
  localparam int X_W    = AW + 1;
  localparam int MUL_W  = $clog2(2 * SECTORS_PER_TURN + 1);
  localparam int PROD_W = X_W + MUL_W + 1;
  localparam int RAW_W  = $clog2(2 * SECTORS_PER_TURN);
  localparam int Q_W    = RAW_W - 2;

  localparam logic [X_W-1:0]    TURN   = X_W'(1) << AW;
  localparam logic [MUL_W-1:0]  TWO_S  = MUL_W'(2 * SECTORS_PER_TURN);
  // floor(raw/6) as (raw*171)>>10, exact for raw < 192
  localparam int RECIP_W     = 8;
  localparam int RECIP_SHIFT = 10;
  localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'(171);

  localparam logic [SEC_W-1:0] STEP_FWD = SEC_W'(1);
  localparam logic [SEC_W-1:0] STEP_REV = SEC_W'(4);
  localparam logic [SEC_W-1:0] STEP_NONE = SEC_W'(0);
  localparam logic [SEC_W:0]   SIX = (SEC_W + 1)'(6);

  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_MAX_DUTY = 2'd1;
  localparam logic [1:0] REG_OFFSET   = 2'd2;

  localparam logic [MAG_W-1:0] MAX_DUTY_RST = MAG_W'(16384);
  localparam logic [AW-1:0]    OFFSET_RST   = AW'(8001);

  typedef enum logic [1:0] {
    PH_OPEN = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t u;
    phase_t v;
    phase_t w;
  } drive_t;

  typedef struct packed {
    logic              enable;
    logic [MAG_W-1:0]  max_duty;
    logic [AW-1:0]     angle_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0] cmd;
    logic [RAW_W-1:0]         raw;
    logic [Q_W-1:0]           q;
  } sec_item_t;

  function automatic drive_t phase_lookup(input logic [SEC_W-1:0] sec);
    drive_t d;
    d = '{PH_OPEN, PH_OPEN, PH_OPEN};
    unique case (sec)
      3'd0: d = '{PH_OPEN, PH_LOW,  PH_HIGH};
      3'd1: d = '{PH_HIGH, PH_LOW,  PH_OPEN};
      3'd2: d = '{PH_HIGH, PH_OPEN, PH_LOW };
      3'd3: d = '{PH_OPEN, PH_HIGH, PH_LOW };
      3'd4: d = '{PH_LOW,  PH_HIGH, PH_OPEN};
      3'd5: d = '{PH_LOW,  PH_OPEN, PH_HIGH};
      default: d = '{PH_OPEN, PH_OPEN, PH_OPEN};
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/bssc_in_if.sv
// ----------------------------------------------------------------------------
// bssc_in_if
// Input item channel: rotor angle and signed duty command.
// ----------------------------------------------------------------------------
interface bssc_in_if import bssc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ANGLE_W-1:0]       rotor_angle;
  logic signed [DUTY_W-1:0] duty_command;

  modport source (output valid, rotor_angle, duty_command, input ready);
  modport sink   (input valid, rotor_angle, duty_command, output ready);
endinterface

FILE: hdl/bssc_out_if.sv
// ----------------------------------------------------------------------------
// bssc_out_if
// Result item channel: gate drive per phase, sector and applied duty.
// ----------------------------------------------------------------------------
interface bssc_out_if import bssc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MAG_W-1:0]         u_high_duty;
  logic                     u_low_on;
  logic [MAG_W-1:0]         v_high_duty;
  logic                     v_low_on;
  logic [MAG_W-1:0]         w_high_duty;
  logic                     w_low_on;
  logic [SEC_W-1:0]         sector;
  logic signed [DUTY_W-1:0] applied_duty;

  modport source (output valid, u_high_duty, u_low_on, v_high_duty, v_low_on,
                  w_high_duty, w_low_on, sector, applied_duty, input ready);
  modport sink   (input valid, u_high_duty, u_low_on, v_high_duty, v_low_on,
                  w_high_duty, w_low_on, sector, applied_duty, output ready);
endinterface

FILE: hdl/bssc_regs.sv
// ----------------------------------------------------------------------------
// bssc_regs
// APB configuration registers: enable, max duty, angle offset.
// ----------------------------------------------------------------------------
module bssc_regs import bssc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic             enable_r, enable_nxt;
  logic [MAG_W-1:0] max_duty_r, max_duty_nxt;
  logic [AW-1:0]    offset_r, offset_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    enable_nxt   = enable_r;
    max_duty_nxt = max_duty_r;
    offset_nxt   = offset_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_ENABLE:   enable_nxt   = pwdata[0];
        REG_MAX_DUTY: max_duty_nxt = pwdata[MAG_W-1:0];
        REG_OFFSET:   offset_nxt   = pwdata[AW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      max_duty_r <= MAX_DUTY_RST;
      offset_r   <= OFFSET_RST;
    end else begin
      enable_r   <= enable_nxt;
      max_duty_r <= max_duty_nxt;
      offset_r   <= offset_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE:   prdata = 32'(enable_r);
      REG_MAX_DUTY: prdata = 32'(max_duty_r);
      REG_OFFSET:   prdata = 32'(offset_r);
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg = '{enable: enable_r, max_duty: max_duty_r, angle_offset: offset_r};

endmodule

FILE: hdl/bssc_sector.sv
// ----------------------------------------------------------------------------
// bssc_sector
// Three pipeline stages: clamp and angle difference, sector scaling
// multiply, divide-by-six reciprocal multiply.
// ----------------------------------------------------------------------------
module bssc_sector import bssc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  bssc_in_if.sink   in_ch,
  output logic      sec_valid,
  input  logic      sec_ready,
  output sec_item_t sec_item
);

  // stage 1
  logic                     v1_r;
  logic signed [DUTY_W-1:0] cmd1_r, cmd1_nxt;
  logic [X_W-1:0]           x1_r, x1_nxt;
  // stage 2
  logic                     v2_r;
  logic signed [DUTY_W-1:0] cmd2_r;
  logic [RAW_W-1:0]         raw2_r, raw2_nxt;
  // stage 3
  logic                     v3_r;
  logic signed [DUTY_W-1:0] cmd3_r;
  logic [RAW_W-1:0]         raw3_r;
  logic [Q_W-1:0]           q3_r, q3_nxt;

  logic rdy1, rdy2, rdy3;
  logic signed [DUTY_W:0] cmd_x, lim_x, nlim_x, cmd_c;
  logic [PROD_W-1:0]              prod2;
  logic [RAW_W+RECIP_W-1:0]       prod3;

  assign rdy3 = !v3_r | sec_ready;
  assign rdy2 = !v2_r | rdy3;
  assign rdy1 = !v1_r | rdy2;
  assign in_ch.ready = rdy1;

  always_comb begin
    cmd_x  = {in_ch.duty_command[DUTY_W-1], in_ch.duty_command};
    lim_x  = {2'b00, cfg.max_duty};
    nlim_x = -lim_x;
    priority if (cmd_x > lim_x) begin
      cmd_c = lim_x;
    end else if (cmd_x < nlim_x) begin
      cmd_c = nlim_x;
    end else begin
      cmd_c = cmd_x;
    end
    cmd1_nxt = cmd_c[DUTY_W-1:0];
    x1_nxt   = X_W'(cfg.angle_offset) + TURN - X_W'(AW'(in_ch.rotor_angle));
  end

  assign prod2    = PROD_W'(x1_r) * PROD_W'(TWO_S) + PROD_W'(TURN);
  assign raw2_nxt = RAW_W'(prod2 >> X_W);

  assign prod3  = (RAW_W + RECIP_W)'(raw2_r) * (RAW_W + RECIP_W)'(RECIP6);
  assign q3_nxt = Q_W'(prod3 >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      cmd1_r <= cmd1_nxt;
      x1_r   <= x1_nxt;
    end
    if (rdy2 && v1_r) begin
      cmd2_r <= cmd1_r;
      raw2_r <= raw2_nxt;
    end
    if (rdy3 && v2_r) begin
      cmd3_r <= cmd2_r;
      raw3_r <= raw2_r;
      q3_r   <= q3_nxt;
    end
  end

  assign sec_valid = v3_r;
  assign sec_item  = '{cmd: cmd3_r, raw: raw3_r, q: q3_r};

endmodule

FILE: hdl/bssc_drive.sv
// ----------------------------------------------------------------------------
// bssc_drive
// Final stage: sector mod 6, direction step, phase table, gate outputs.
// ----------------------------------------------------------------------------
module bssc_drive import bssc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      sec_valid,
  output logic      sec_ready,
  input  sec_item_t sec_item,
  bssc_out_if.source out_ch
);

  logic                     out_valid_r;
  logic [MAG_W-1:0]         u_hi_r, v_hi_r, w_hi_r, u_hi_nxt, v_hi_nxt, w_hi_nxt;
  logic                     u_lo_r, v_lo_r, w_lo_r, u_lo_nxt, v_lo_nxt, w_lo_nxt;
  logic [SEC_W-1:0]         sector_r, sector_nxt;
  logic signed [DUTY_W-1:0] duty_r;

  logic [RAW_W:0]   six_q;
  logic [SEC_W-1:0] base, step;
  logic [SEC_W:0]   sum;
  logic [MAG_W-1:0] mag;
  logic signed [DUTY_W-1:0] neg_cmd;
  drive_t           drv;

  assign sec_ready = !out_valid_r | out_ch.ready;

  always_comb begin
    six_q = ((RAW_W + 1)'(sec_item.q) << 2) + ((RAW_W + 1)'(sec_item.q) << 1);
    base  = SEC_W'((RAW_W + 1)'(sec_item.raw) - six_q);
    priority if (sec_item.cmd > 0) begin
      step = STEP_FWD;
    end else if (sec_item.cmd < 0) begin
      step = STEP_REV;
    end else begin
      step = STEP_NONE;
    end
    sum = (SEC_W + 1)'(base) + (SEC_W + 1)'(step);
    if (sum >= SIX) begin
      sum = sum - SIX;
    end
    sector_nxt = sum[SEC_W-1:0];
    neg_cmd    = -sec_item.cmd;
    mag        = sec_item.cmd[DUTY_W-1] ? neg_cmd[MAG_W-1:0] : sec_item.cmd[MAG_W-1:0];
    drv        = phase_lookup(sector_nxt);
    u_hi_nxt   = (cfg.enable && drv.u == PH_HIGH) ? mag : '0;
    v_hi_nxt   = (cfg.enable && drv.v == PH_HIGH) ? mag : '0;
    w_hi_nxt   = (cfg.enable && drv.w == PH_HIGH) ? mag : '0;
    u_lo_nxt   = cfg.enable && drv.u == PH_LOW;
    v_lo_nxt   = cfg.enable && drv.v == PH_LOW;
    w_lo_nxt   = cfg.enable && drv.w == PH_LOW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sec_ready) begin
      out_valid_r <= sec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sec_ready && sec_valid) begin
      u_hi_r   <= u_hi_nxt;
      v_hi_r   <= v_hi_nxt;
      w_hi_r   <= w_hi_nxt;
      u_lo_r   <= u_lo_nxt;
      v_lo_r   <= v_lo_nxt;
      w_lo_r   <= w_lo_nxt;
      sector_r <= sector_nxt;
      duty_r   <= sec_item.cmd;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.u_high_duty  = u_hi_r;
  assign out_ch.u_low_on     = u_lo_r;
  assign out_ch.v_high_duty  = v_hi_r;
  assign out_ch.v_low_on     = v_lo_r;
  assign out_ch.w_high_duty  = w_hi_r;
  assign out_ch.w_low_on     = w_lo_r;
  assign out_ch.sector       = sector_r;
  assign out_ch.applied_duty = duty_r;

endmodule

FILE: hdl/bldc_six_step_commutation.sv
// Path from input accept to result valid: 3 datapath stages plus an output register.
// Throughput: 1 item per cycle; each stage advances when its successor has room.
// The two multipliers (angle scaling, divide-by-six reciprocal) each own one stage.
// Reset (rst_n low, synchronous): pipeline emptied, enable 0, max_duty 16384,
// angle_offset 8001.
// ----------------------------------------------------------------------------
// bldc_six_step_commutation
// Six-step BLDC commutation: duty clamp, angle to sector, phase gate drive.
// ----------------------------------------------------------------------------
module bldc_six_step_commutation import bssc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bssc_in_if.sink            in_ch,
  bssc_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t      cfg;
  logic      sec_valid;
  logic      sec_ready;
  sec_item_t sec_item;

  bssc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bssc_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .sec_valid (sec_valid),
    .sec_ready (sec_ready),
    .sec_item  (sec_item)
  );

  bssc_drive u_drive (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .sec_valid (sec_valid),
    .sec_ready (sec_ready),
    .sec_item  (sec_item),
    .out_ch    (out_ch)
  );

endmodule

FILE: hdl/bssc_chk.sv
// ----------------------------------------------------------------------------
// bssc_chk
// Port-level checks on the commutation block's result channel.
// ----------------------------------------------------------------------------
module bssc_chk import bssc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [MAG_W-1:0]         u_high_duty,
  input logic                     u_low_on,
  input logic [MAG_W-1:0]         v_high_duty,
  input logic                     v_low_on,
  input logic [MAG_W-1:0]         w_high_duty,
  input logic                     w_low_on,
  input logic [SEC_W-1:0]         sector,
  input logic signed [DUTY_W-1:0] applied_duty
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sector) && $stable(applied_duty))
    else $error("stalled item changed");

  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sector <= SEC_W'(5))
    else $error("sector out of range");

  a_one_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({u_low_on, v_low_on, w_low_on}) <= 1)
    else $error("more than one low side on");

  a_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (u_high_duty != 0 || v_high_duty != 0 || w_high_duty != 0) |->
      applied_duty != 0 &&
      (u_high_duty == 0 || v_high_duty == 0) && (u_high_duty == 0 || w_high_duty == 0) &&
      (v_high_duty == 0 || w_high_duty == 0))
    else $error("high side drive inconsistent with duty");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("item valid after reset");

endmodule

bind bldc_six_step_commutation bssc_chk u_bssc_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .u_high_duty  (out_ch.u_high_duty),
  .u_low_on     (out_ch.u_low_on),
  .v_high_duty  (out_ch.v_high_duty),
  .v_low_on     (out_ch.v_low_on),
  .w_high_duty  (out_ch.w_high_duty),
  .w_low_on     (out_ch.w_low_on),
  .sector       (out_ch.sector),
  .applied_duty (out_ch.applied_duty)
);

FILE: dv/tb_bldc_six_step_commutation.sv
// ----------------------------------------------------------------------------
// tb_bldc_six_step_commutation
// Self-checking bench for the six-step commutation block. A short table of
// directed items covers reset values, duty extremes, the disabled bridge, a
// zero duty limit and angle wrap. Random phases with different register
// settings follow. Each result is checked against a typed row or a gate-drive
// predictor. Both channels idle in random bursts outside the last two phases.
// ----------------------------------------------------------------------------
module tb_bldc_six_step_commutation;
  import bssc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PIPE_DRAIN   = 8;
  localparam int N_PHASES     = 11;
  localparam int PHASE_ITEMS  = 150;
  localparam int FULL_TURN    = 1 << ANGLE_BITS;
  localparam int MAX_CMD      = (1 << (DUTY_W - 1)) - 1;
  localparam int MIN_CMD      = -(1 << (DUTY_W - 1));

  typedef struct {
    logic [MAG_W-1:0]         u_hi;
    logic                     u_lo;
    logic [MAG_W-1:0]         v_hi;
    logic                     v_lo;
    logic [MAG_W-1:0]         w_hi;
    logic                     w_lo;
    logic [SEC_W-1:0]         sector;
    logic signed [DUTY_W-1:0] applied;
  } gate_res_t;

  typedef struct {
    logic                     en;
    logic [MAG_W-1:0]         maxd;
    logic [ANGLE_W-1:0]       offs;
    logic [ANGLE_W-1:0]       angle;
    logic signed [DUTY_W-1:0] duty;
    bit                       typed;
    gate_res_t                res;
  } vec_t;

  // U, V, W drive per commutation state
  phase_t gate_map [6][3] = '{
    '{PH_OPEN, PH_LOW,  PH_HIGH},
    '{PH_HIGH, PH_LOW,  PH_OPEN},
    '{PH_HIGH, PH_OPEN, PH_LOW },
    '{PH_OPEN, PH_HIGH, PH_LOW },
    '{PH_LOW,  PH_HIGH, PH_OPEN},
    '{PH_LOW,  PH_OPEN, PH_HIGH}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  bssc_in_if  in_if ();
  bssc_out_if out_if ();

  logic               cur_en;
  logic [MAG_W-1:0]   cur_maxd;
  logic [ANGLE_W-1:0] cur_offs;

  gate_res_t gate_q [$];
  vec_t      dir_rows [$];
  gate_res_t mon_e;
  bit        idle_on = 1'b1;
  int        n_cyc = 0;
  int        n_in = 0;
  int        n_res = 0;
  int        n_err = 0;
  int        n_wr = 0;

  bldc_six_step_commutation u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (psel),
    .cfg_penable (penable),
    .cfg_pwrite  (pwrite),
    .cfg_paddr   (paddr),
    .cfg_pwdata  (pwdata),
    .cfg_prdata  (prdata),
    .cfg_pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) n_cyc <= n_cyc + 1;

  initial begin
    while (n_cyc < LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending", n_cyc, gate_q.size());
    $display("** bldc_six_step_commutation: FAILED **");
    $finish;
  end

  function automatic gate_res_t predict_gates(input logic [ANGLE_W-1:0] ang,
                                              input logic signed [DUTY_W-1:0] cmd);
    gate_res_t          r;
    logic signed [DUTY_W:0] lim;
    logic signed [DUTY_W:0] c;
    logic [MAG_W-1:0]   mag;
    int                 xi;
    int                 raw;
    logic [SEC_W-1:0]   step;
    logic [SEC_W-1:0]   sec;
    phase_t             pu, pv, pw;
    lim = $signed({2'b00, cur_maxd});
    c = cmd;
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    mag = (c < 0) ? MAG_W'(-c) : MAG_W'(c);
    xi = int'(cur_offs) + FULL_TURN - int'(ang);
    raw = (xi * 2 * SECTORS_PER_TURN + FULL_TURN) / (2 * FULL_TURN);
    step = (c > 0) ? STEP_FWD : (c < 0) ? STEP_REV : STEP_NONE;
    sec = SEC_W'(((raw % 6) + int'(step)) % 6);
    pu = cur_en ? gate_map[sec][0] : PH_OPEN;
    pv = cur_en ? gate_map[sec][1] : PH_OPEN;
    pw = cur_en ? gate_map[sec][2] : PH_OPEN;
    r.u_hi = (pu == PH_HIGH) ? mag : '0;
    r.u_lo = (pu == PH_LOW);
    r.v_hi = (pv == PH_HIGH) ? mag : '0;
    r.v_lo = (pv == PH_LOW);
    r.w_hi = (pw == PH_HIGH) ? mag : '0;
    r.w_lo = (pw == PH_LOW);
    r.sector = sec;
    r.applied = c[DUTY_W-1:0];
    return r;
  endfunction

  function automatic gate_res_t mk_res(input int u_hi, input int u_lo, input int v_hi,
                                       input int v_lo, input int w_hi, input int w_lo,
                                       input int sec, input int app);
    gate_res_t r;
    r.u_hi = MAG_W'(u_hi);
    r.u_lo = u_lo[0];
    r.v_hi = MAG_W'(v_hi);
    r.v_lo = v_lo[0];
    r.w_hi = MAG_W'(w_hi);
    r.w_lo = w_lo[0];
    r.sector = SEC_W'(sec);
    r.applied = DUTY_W'(app);
    return r;
  endfunction

  function automatic void add_row(input int en, input int maxd, input int offs,
                                  input int ang, input int duty);
    vec_t v;
    v.en = en[0];
    v.maxd = MAG_W'(maxd);
    v.offs = ANGLE_W'(offs);
    v.angle = ANGLE_W'(ang);
    v.duty = DUTY_W'(duty);
    v.typed = 1'b0;
    dir_rows.push_back(v);
  endfunction

  function automatic void add_typed(input int en, input int maxd, input int offs,
                                    input int ang, input int duty, input gate_res_t r);
    add_row(en, maxd, offs, ang, duty);
    dir_rows[$].typed = 1'b1;
    dir_rows[$].res = r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    n_wr++;
  endtask

  // called at a falling edge; lowers valid and lets the pipe empty first
  task automatic set_config(input logic en, input logic [MAG_W-1:0] maxd,
                            input logic [ANGLE_W-1:0] offs);
    in_if.valid = 1'b0;
    while (gate_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    apb_write(REG_ENABLE, 32'(en));
    apb_write(REG_MAX_DUTY, 32'(maxd));
    apb_write(REG_OFFSET, 32'(offs));
    cur_en = en;
    cur_maxd = maxd;
    cur_offs = offs;
  endtask

  // entered and left at a falling edge; valid stays high for back-to-back items
  task automatic send_item(input logic [ANGLE_W-1:0] ang,
                           input logic signed [DUTY_W-1:0] duty,
                           input bit typed, input gate_res_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.rotor_angle = ang;
    in_if.duty_command = duty;
    do @(posedge clk); while (!in_if.ready);
    gate_q.push_back(typed ? res : predict_gates(ang, duty));
    n_in++;
    @(negedge clk);
  endtask

  function automatic logic [ANGLE_W-1:0] pick_angle();
    int k;
    int xb;
    int v;
    if ($urandom_range(0, 9) < 7) return ANGLE_W'($urandom_range(0, FULL_TURN - 1));
    // land near a sector boundary
    k = $urandom_range(1, 2 * SECTORS_PER_TURN - 1);
    xb = (k * 2 * FULL_TURN - FULL_TURN) / (2 * SECTORS_PER_TURN);
    v = int'(cur_offs) + 3 * FULL_TURN - xb + $urandom_range(0, 4) - 2;
    return ANGLE_W'(v % FULL_TURN);
  endfunction

  function automatic logic signed [DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 9))
      0: return DUTY_W'(MAX_CMD);
      1: return DUTY_W'(MIN_CMD);
      2: return '0;
      3: return DUTY_W'(cur_maxd);
      4: return DUTY_W'(-int'(cur_maxd));
      5: return DUTY_W'(int'(cur_maxd) + 1);
      default: return DUTY_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_if.ready = 1'b0;
      end else if (!idle_on || $urandom_range(0, 3) != 0) begin
        out_if.ready = 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (gate_q.size() == 0) begin
        $error("result item with nothing expected");
        n_err++;
      end else begin
        mon_e = gate_q.pop_front();
        check_field("u_high_duty", mon_e.u_hi, out_if.u_high_duty);
        check_field("u_low_on", mon_e.u_lo, out_if.u_low_on);
        check_field("v_high_duty", mon_e.v_hi, out_if.v_high_duty);
        check_field("v_low_on", mon_e.v_lo, out_if.v_low_on);
        check_field("w_high_duty", mon_e.w_hi, out_if.w_high_duty);
        check_field("w_low_on", mon_e.w_lo, out_if.w_low_on);
        check_field("sector", mon_e.sector, out_if.sector);
        check_field("applied_duty", int'(mon_e.applied), int'(out_if.applied_duty));
        n_res++;
      end
    end
  end

  initial begin
    vec_t      v;
    gate_res_t none;
    logic                 p_en;
    logic [MAG_W-1:0]     p_maxd;
    logic [ANGLE_W-1:0]   p_offs;

    in_if.valid = 1'b0;
    in_if.rotor_angle = '0;
    in_if.duty_command = '0;
    none = mk_res(0, 0, 0, 0, 0, 0, 0, 0);

    // reset values: bridge off, limit 16384, offset 8001
    add_typed(0, 16384, 8001, 8001, 0, mk_res(0, 0, 0, 0, 0, 0, 0, 0));
    add_typed(0, 16384, 8001, 8001, MAX_CMD, mk_res(0, 0, 0, 0, 0, 0, 1, 16384));
    add_typed(0, 16384, 8001, 8001, MIN_CMD, mk_res(0, 0, 0, 0, 0, 0, 4, -16384));
    add_row(0, 16384, 8001, 0, 1);
    add_row(0, 16384, 8001, FULL_TURN - 1, -1);
    add_row(0, 16384, 8001, 8000, 16385);
    add_row(0, 16384, 8001, 8002, -16385);
    // full limit, bridge on
    add_typed(1, 32767, 8001, 8001, MAX_CMD, mk_res(32767, 0, 0, 1, 0, 0, 1, 32767));
    add_typed(1, 32767, 8001, 8001, MIN_CMD, mk_res(0, 1, 32767, 0, 0, 0, 4, -32767));
    add_typed(1, 32767, 8001, 8001, 0, mk_res(0, 0, 0, 1, 0, 0, 0, 0));
    add_row(1, 32767, 8001, 0, 12345);
    add_row(1, 32767, 8001, FULL_TURN - 1, -20000);
    add_row(1, 32767, 8001, 4096, MAX_CMD);
    add_row(1, 32767, 8001, 12288, -1);
    // zero limit
    add_typed(1, 0, 0, 0, MAX_CMD, mk_res(0, 0, 0, 1, 0, 0, 0, 0));
    add_row(1, 0, 0, FULL_TURN - 1, MIN_CMD);
    add_row(1, 0, 0, 5000, 100);
    // unit limit, top offset; then reset limit and offset with bridge on
    add_typed(1, 1, FULL_TURN - 1, FULL_TURN - 1, MAX_CMD, mk_res(1, 0, 0, 1, 0, 0, 1, 1));
    add_typed(1, 1, FULL_TURN - 1, FULL_TURN - 1, MIN_CMD, mk_res(0, 1, 1, 0, 0, 0, 4, -1));
    add_row(1, 1, FULL_TURN - 1, 0, -1);
    add_row(1, 1, FULL_TURN - 1, 8191, 2);
    add_row(1, 16384, 8001, 1000, 16384);
    add_row(1, 16384, 8001, 9000, -16384);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    cur_en = 1'b0;
    cur_maxd = MAX_DUTY_RST;
    cur_offs = OFFSET_RST;

    foreach (dir_rows[i]) begin
      v = dir_rows[i];
      if (v.en != cur_en || v.maxd != cur_maxd || v.offs != cur_offs)
        set_config(v.en, v.maxd, v.offs);
      send_item(v.angle, v.duty, v.typed, v.res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      p_en = 1'b1;
      p_maxd = MAG_W'($urandom_range(0, 32767));
      p_offs = ANGLE_W'($urandom_range(0, FULL_TURN - 1));
      case (ph)
        0: begin p_maxd = 15'd32767; p_offs = '0; end
        1: begin p_maxd = '0; p_offs = ANGLE_W'(FULL_TURN - 1); end
        2: p_en = 1'b0;
        3: begin p_maxd = MAX_DUTY_RST; p_offs = OFFSET_RST; end
        4: p_maxd = 15'd1;
        10: begin p_maxd = 15'd32767; p_offs = ANGLE_W'(FULL_TURN - 1); end
        default: ;
      endcase
      set_config(p_en, p_maxd, p_offs);
      idle_on = (ph < N_PHASES - 2);
      repeat (PHASE_ITEMS) send_item(pick_angle(), pick_duty(), 1'b0, none);
    end
    in_if.valid = 1'b0;

    while (gate_q.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (gate_q.size() != 0) n_err++;

    $display("covered %0d items, %0d results, %0d register writes, %0d mismatches",
             n_in, n_res, n_wr, n_err);
    $display("settings: reset, full and zero limits, bridge off, offset 0 and top");
    if (n_err == 0) begin
      $display("** bldc_six_step_commutation: PASSED **");
    end else begin
      $display("** bldc_six_step_commutation: FAILED **");
    end
    $finish;
  end

endmodule
